// ===== rtl/core/cubic_bezier_point_evaluator_assert.svh =====
// Assertion macros for the cubic Bezier point evaluator.
// Included by the top level; needs nothing else.
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BZR_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BZR_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bzr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the divider step function of the Bezier evaluator.
// Used by every module in rtl/core; depends on nothing.
package bzr_pkg;

  // Input field width and limits.
  localparam int IDX_BITS      = 13;
  localparam int MAX_SEGMENTS  = 4096;
  localparam int IN_TDATA_BITS = ((2 * IDX_BITS + 7) / 8) * 8;

  // Default coordinate width (signed Q2.14).
  localparam int COORD_BITS_DEF = 16;

  // Curve parameter: Q0.16 plus one bit so that t = 1 is exact.
  localparam int Q_BITS = 16;
  localparam int T_BITS = Q_BITS + 1;
  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << Q_BITS;

  // Weight widths: products of three parameters, cut to Q0.24.
  localparam int SQ_BITS = 2 * T_BITS;
  localparam int CU_BITS = 3 * T_BITS;
  localparam int W_DROP  = 24;
  localparam int W_BITS  = W_DROP + 1;

  // Pipeline shape.
  localparam int DIV_STAGES         = 4;
  localparam int DIV_BITS_PER_STAGE = Q_BITS / DIV_STAGES;
  localparam int WGT_STAGES         = 3;
  localparam int MAC_STAGES         = 3;
  localparam int PIPE_DEPTH         = DIV_STAGES + WGT_STAGES + MAC_STAGES;
  localparam int OCC_BITS           = $clog2(PIPE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 4;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } cfg_reg_t;

  // Divider working item.
  typedef struct packed {
    logic [IDX_BITS-1:0] rem;
    logic [IDX_BITS-1:0] divisor;
    logic [Q_BITS-1:0]   quot;
    logic                t_one;
    logic                is_last;
  } div_item_t;

  // Curve parameter handed from divider to weight unit.
  typedef struct packed {
    logic [T_BITS-1:0] t;
    logic              is_last;
  } t_item_t;

  // Truncated Bernstein weights handed to the multiply-accumulate unit.
  typedef struct packed {
    logic [3:0][W_BITS-1:0] w;
    logic                   is_last;
  } wgt_item_t;

  // A few restoring division steps: one quotient bit per step.
  function automatic div_item_t div_steps(div_item_t d);
    div_item_t          r;
    logic [IDX_BITS:0]  sh;
    r = d;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.divisor}) begin
        sh     = sh - {1'b0, r.divisor};
        r.quot = {r.quot[Q_BITS-2:0], 1'b1};
      end else begin
        r.quot = {r.quot[Q_BITS-2:0], 1'b0};
      end
      r.rem = sh[IDX_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cubic_bezier_point_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the 2D cubic Bezier point evaluator: control point registers,
// stream ports and the divider, weight and multiply-accumulate pipelines.
// Depends on bzr_pkg, bzr_div, bzr_wgt, bzr_mac and the assertion header.
//
//   Channel   Direction  Transaction carries
//   s_axis    in         step_index, segment_count
//   m_axis    out        point_x, point_y, is_last (as tlast)
//   cfg       in         control point register index and value
//
// One item is accepted per cycle unless a full pipeline is held by a stalled output; each
// transaction passes through four divider stages, three weight stages and three multiply-add stages.
// Every stage holds its own valid bit, so bubbles fill while the output is stalled.
// Reset clears all valid bits and sets the control points to zero.
// Configuration writes are always accepted and take effect in the next cycle.
module cubic_bezier_point_evaluator #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF,
  localparam int OUT_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // Fields from bit 0: step_index[12:0], segment_count[25:13], zero pad.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bzr_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // Fields from bit 0: point_x, point_y, zero pad.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0]          m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bzr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data
);
  import bzr_pkg::*;

  `include "cubic_bezier_point_evaluator_assert.svh"

  logic [1:0][3:0][COORD_BITS-1:0] ctrl_pt;
  logic                            div_valid, div_ready;
  t_item_t                         div_item;
  logic                            wgt_valid, wgt_ready;
  wgt_item_t                       wgt_item;
  logic [COORD_BITS-1:0]           point_x, point_y;
  logic                            in_acc, out_acc;
  logic [OCC_BITS-1:0]             occ, occ_next;

  // Control point registers; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_pt <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_P0_X: ctrl_pt[0][0] <= cfg_data;
        REG_P0_Y: ctrl_pt[1][0] <= cfg_data;
        REG_P1_X: ctrl_pt[0][1] <= cfg_data;
        REG_P1_Y: ctrl_pt[1][1] <= cfg_data;
        REG_P2_X: ctrl_pt[0][2] <= cfg_data;
        REG_P2_Y: ctrl_pt[1][2] <= cfg_data;
        REG_P3_X: ctrl_pt[0][3] <= cfg_data;
        REG_P3_Y: ctrl_pt[1][3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parameter division.
  bzr_div u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .step_index    (s_axis_tdata[IDX_BITS-1:0]),
    .segment_count (s_axis_tdata[2*IDX_BITS-1:IDX_BITS]),
    .out_valid     (div_valid),
    .out_ready     (div_ready),
    .out_item      (div_item)
  );

  // Bernstein weights.
  bzr_wgt u_wgt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_item   (div_item),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_item  (wgt_item)
  );

  // Weighted sum, rounding and saturation; its last stage is the output register.
  bzr_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_item   (wgt_item),
    .coord     (ctrl_pt),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .point_x   (point_x),
    .point_y   (point_y),
    .is_last   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'({point_y, point_x});

  // Count of items in flight, for the checks below.
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign occ_next = occ + OCC_BITS'(in_acc) - OCC_BITS'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  `BZR_ASSERT_IMPL(a_empty_ready, clk, rst, occ == '0, s_axis_tready, "empty pipeline not ready")
  `BZR_ASSERT_IMPL(a_empty_no_out, clk, rst, occ == '0, !m_axis_tvalid, "result with no item in flight")
  `BZR_ASSERT_IMPL(a_full_stall, clk, rst, (occ == OCC_BITS'(PIPE_DEPTH)) && !m_axis_tready, !s_axis_tready, "full stalled pipeline took an item")
  `BZR_ASSERT_NEXT(a_min_latency, clk, rst, (occ == '0) && in_acc, !m_axis_tvalid, "result came out too early")

endmodule

// ===== rtl/core/bzr_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider that forms t = step_index / segment_count in Q0.16.
// Depends on bzr_pkg.
module bzr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bzr_pkg::IDX_BITS-1:0]  step_index,
  input  logic [bzr_pkg::IDX_BITS-1:0]  segment_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bzr_pkg::t_item_t              out_item
);
  import bzr_pkg::*;

  logic [IDX_BITS-1:0] seg_eff;
  div_item_t           prep;
  div_item_t           stg       [DIV_STAGES];
  logic                stg_valid [DIV_STAGES];
  logic                adv       [DIV_STAGES];
  logic                nxt_ready [DIV_STAGES];

  // Clamp the count, flag t = 1 and seed the remainder.
  always_comb begin
    if (segment_count == '0) begin
      seg_eff = IDX_BITS'(1);
    end else if (32'(segment_count) > MAX_SEGMENTS) begin
      seg_eff = IDX_BITS'(MAX_SEGMENTS);
    end else begin
      seg_eff = segment_count;
    end
    prep.divisor = seg_eff;
    prep.t_one   = (step_index >= seg_eff);
    prep.rem     = prep.t_one ? '0 : step_index;
    prep.quot    = '0;
    prep.is_last = (step_index == segment_count);
  end

  // Divider stages, each retiring a few quotient bits.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_item_t stg_src;
    logic      src_valid;

    if (k == 0) begin : g_first
      assign stg_src   = prep;
      assign src_valid = in_valid;
    end else begin : g_rest
      assign stg_src   = stg[k-1];
      assign src_valid = stg_valid[k-1];
    end

    if (k == DIV_STAGES - 1) begin : g_last
      assign nxt_ready[k] = out_ready;
    end else begin : g_mid
      assign nxt_ready[k] = adv[k+1];
    end

    assign adv[k] = !stg_valid[k] || nxt_ready[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (adv[k]) begin
        stg_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stg[k] <= div_steps(stg_src);
      end
    end
  end

  // Hand the finished parameter downstream.
  assign in_ready          = adv[0];
  assign out_valid         = stg_valid[DIV_STAGES-1];
  assign out_item.t        = stg[DIV_STAGES-1].t_one ? T_ONE
                                                     : {1'b0, stg[DIV_STAGES-1].quot};
  assign out_item.is_last  = stg[DIV_STAGES-1].is_last;

endmodule

// ===== rtl/core/bzr_wgt.sv =====
`timescale 1ns / 1ps
// Three-stage unit that forms the four Bernstein weights from t, cut to Q0.24.
// Depends on bzr_pkg.
module bzr_wgt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bzr_pkg::t_item_t     in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bzr_pkg::wgt_item_t   out_item
);
  import bzr_pkg::*;

  logic                 a_valid, b_valid, c_valid;
  logic                 adv_a, adv_b, adv_c;
  logic [T_BITS-1:0]    s_calc;
  logic [T_BITS-1:0]    a_t, a_s;
  logic [SQ_BITS-1:0]   a_s2, a_t2;
  logic                 a_last;
  logic [CU_BITS-1:0]   b_c0, b_c1, b_c2, b_c3;
  logic                 b_last;
  logic [CU_BITS+1:0]   c1_x3, c2_x3;
  wgt_item_t            c_item;

  assign adv_c    = !c_valid || out_ready;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= in_valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
    end
  end

  // Stage A: complement and squares.
  assign s_calc = T_ONE - in_item.t;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_t    <= in_item.t;
      a_s    <= s_calc;
      a_s2   <= SQ_BITS'(s_calc) * SQ_BITS'(s_calc);
      a_t2   <= SQ_BITS'(in_item.t) * SQ_BITS'(in_item.t);
      a_last <= in_item.is_last;
    end
  end

  // Stage B: the four cubic products.
  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_c0   <= CU_BITS'(a_s2) * CU_BITS'(a_s);
      b_c1   <= CU_BITS'(a_s2) * CU_BITS'(a_t);
      b_c2   <= CU_BITS'(a_t2) * CU_BITS'(a_s);
      b_c3   <= CU_BITS'(a_t2) * CU_BITS'(a_t);
      b_last <= a_last;
    end
  end

  // Stage C: scale the middle terms by three and drop the low bits.
  assign c1_x3 = {2'b00, b_c1} + {1'b0, b_c1, 1'b0};
  assign c2_x3 = {2'b00, b_c2} + {1'b0, b_c2, 1'b0};

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_item.w[0]    <= b_c0[W_DROP +: W_BITS];
      c_item.w[1]    <= c1_x3[W_DROP +: W_BITS];
      c_item.w[2]    <= c2_x3[W_DROP +: W_BITS];
      c_item.w[3]    <= b_c3[W_DROP +: W_BITS];
      c_item.is_last <= b_last;
    end
  end

  assign out_valid = c_valid;
  assign out_item  = c_item;

endmodule

// ===== rtl/core/bzr_mac.sv =====
`timescale 1ns / 1ps
// Three-stage weighted sum of the control points with rounding and saturation.
// Depends on bzr_pkg.
module bzr_mac #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bzr_pkg::wgt_item_t               in_item,
  input  logic [1:0][3:0][COORD_BITS-1:0]  coord,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COORD_BITS-1:0]            point_x,
  output logic [COORD_BITS-1:0]            point_y,
  output logic                             is_last
);
  import bzr_pkg::*;

  localparam int PROD_BITS = W_BITS + 1 + COORD_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int SH_BITS   = ACC_BITS - W_DROP;
  localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(1) << (W_DROP - 1);
  localparam logic [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                          p_valid, s_valid, r_valid;
  logic                          adv_p, adv_s, adv_r;
  logic signed [PROD_BITS-1:0]   prod_next [2][4];
  logic signed [PROD_BITS-1:0]   prod      [2][4];
  logic                          p_last;
  logic signed [ACC_BITS-1:0]    acc_next  [2];
  logic signed [ACC_BITS-1:0]    acc       [2];
  logic                          s_last;
  logic [SH_BITS-1:0]            sh        [2];
  logic [COORD_BITS-1:0]         sat_next  [2];

  assign adv_r    = !r_valid || out_ready;
  assign adv_s    = !s_valid || adv_r;
  assign adv_p    = !p_valid || adv_s;
  assign in_ready = adv_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      if (adv_p) p_valid <= in_valid;
      if (adv_s) s_valid <= p_valid;
      if (adv_r) r_valid <= s_valid;
    end
  end

  // Stage P: eight weight-by-coordinate products.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        prod_next[a][k] = $signed({1'b0, in_item.w[k]}) * $signed(coord[a][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p) begin
      prod   <= prod_next;
      p_last <= in_item.is_last;
    end
  end

  // Stage S: sum per axis plus the half-LSB rounding bias.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      acc_next[a] = ACC_BITS'(prod[a][0]) + ACC_BITS'(prod[a][1])
                  + ACC_BITS'(prod[a][2]) + ACC_BITS'(prod[a][3]) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s) begin
      acc    <= acc_next;
      s_last <= p_last;
    end
  end

  // Stage R: floor shift, then clamp to the signed coordinate range.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sh[a] = acc[a][ACC_BITS-1:W_DROP];
      if ((&sh[a][SH_BITS-1:COORD_BITS-1]) || !(|sh[a][SH_BITS-1:COORD_BITS-1])) begin
        sat_next[a] = sh[a][COORD_BITS-1:0];
      end else if (sh[a][SH_BITS-1]) begin
        sat_next[a] = SAT_LO;
      end else begin
        sat_next[a] = SAT_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_r) begin
      point_x <= sat_next[0];
      point_y <= sat_next[1];
      is_last <= s_last;
    end
  end

  assign out_valid = r_valid;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_point_evaluator: drives control points over cfg and
// curve samples over the input stream and checks every point against a built-in predictor.
// Depends on bzr_pkg and the evaluator RTL.
module tb_top;
  import bzr_pkg::*;

  localparam int COORD         = COORD_BITS_DEF;
  localparam int OUT_BITS      = ((2 * COORD + 7) / 8) * 8;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SHOWN_ERRORS  = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam longint unsigned T_UNITY = 64'd65536;
  localparam int WEIGHT_DROP   = 24;
  // Register indexes past the last control point, which the block ignores.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_FIRST = CFG_IDX_BITS'(REG_P3_Y + 1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LAST  = '1;
  localparam logic signed [COORD-1:0] COORD_MAX = {1'b0, {(COORD - 1){1'b1}}};
  localparam logic signed [COORD-1:0] COORD_MIN = {1'b1, {(COORD - 1){1'b0}}};

  typedef struct packed {
    logic signed [COORD-1:0] x;
    logic signed [COORD-1:0] y;
    logic                    last;
  } curve_point_t;

  typedef logic [COORD-1:0] point_set_t [8];

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [IN_TDATA_BITS-1:0]    s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]         m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [COORD-1:0]            cfg_data = '0;

  // Predictor copy of the control point registers.
  logic signed [COORD-1:0] ctrl_pts [8];
  curve_point_t            pending_points [$];
  int                      error_count = 0;
  int                      cycle_count = 0;
  bit                      sender_gaps = 1'b0;
  bit                      sink_stalls = 1'b0;
  int                      ready_hold = 0;
  int                      ready_pick;
  curve_point_t            want_point;
  curve_point_t            got_point;

  cubic_bezier_point_evaluator DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Blend one axis with the truncated weights, round half up, then saturate.
  function automatic logic signed [COORD-1:0] blend_axis(logic [3:0][W_BITS-1:0] wts,
                                                         int axis);
    longint acc;
    longint rounded;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc += longint'(wts[k]) * longint'(ctrl_pts[2 * k + axis]);
    end
    rounded = (acc + (64'sd1 <<< (WEIGHT_DROP - 1))) >>> WEIGHT_DROP;
    if (rounded > longint'(COORD_MAX)) return COORD_MAX;
    if (rounded < longint'(COORD_MIN)) return COORD_MIN;
    return rounded[COORD-1:0];
  endfunction

  // Curve point at t = index / count, with the count clamped to its legal range.
  function automatic curve_point_t bezier_point(logic [IDX_BITS-1:0] idx,
                                                logic [IDX_BITS-1:0] cnt);
    longint unsigned       eff;
    longint unsigned       t;
    longint unsigned       s;
    logic [3:0][W_BITS-1:0] wts;
    curve_point_t          pt;
    eff = cnt;
    if (eff == 0) eff = 1;
    if (eff > MAX_SEGMENTS) eff = MAX_SEGMENTS;
    if (idx >= eff) t = T_UNITY;
    else t = (longint'(idx) << 16) / eff;
    s = T_UNITY - t;
    wts[0] = W_BITS'((s * s * s) >> WEIGHT_DROP);
    wts[1] = W_BITS'((3 * s * s * t) >> WEIGHT_DROP);
    wts[2] = W_BITS'((3 * s * t * t) >> WEIGHT_DROP);
    wts[3] = W_BITS'((t * t * t) >> WEIGHT_DROP);
    pt.x    = blend_axis(wts, 0);
    pt.y    = blend_axis(wts, 1);
    pt.last = (idx == cnt);
    return pt;
  endfunction

  task automatic report_mismatch(string what, curve_point_t want, curve_point_t got);
    error_count++;
    if (error_count <= SHOWN_ERRORS)
      $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
               $realtime, what, want.x, want.y, want.last, got.x, got.y, got.last);
  endtask

  // Register writes; valid stays high across a burst and drops after the last one.
  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idxs [$],
                           input logic [COORD-1:0] vals [$]);
    for (int i = 0; i < idxs.size(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idxs[i] <= REG_P3_Y) ctrl_pts[idxs[i][2:0]] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Write all eight control point registers in index order.
  task automatic load_points(input point_set_t pts);
    logic [CFG_IDX_BITS-1:0] idxs [$];
    logic [COORD-1:0]        vals [$];
    cfg_reg_t                r;
    logic [CFG_IDX_BITS-1:0] code;
    r = r.first();
    repeat (8) begin
      code = r;
      idxs.insert(idxs.size(), code);
      vals.insert(vals.size(), pts[code[2:0]]);
      r = r.next();
    end
    write_cfg(idxs, vals);
  endtask

  // Send one sample; the expected point is queued when the transaction completes.
  task automatic send_sample(input logic [IDX_BITS-1:0] idx, input logic [IDX_BITS-1:0] cnt);
    int gap;
    gap = sender_gaps ? idle_span() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_BITS'({cnt, idx});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_points.insert(pending_points.size(), bezier_point(idx, cnt));
  endtask

  // Stop sending and wait until every expected point has come out.
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Random control point set, signed Q2.14.
  function automatic point_set_t random_points();
    point_set_t pts;
    foreach (pts[k]) pts[k] = COORD'($urandom());
    return pts;
  endfunction

  // With all registers at reset every point is the origin.
  task automatic test_reset_points();
    send_sample(0, 1);
    send_sample(1, 1);
    send_sample(5, 10);
    drain_points();
  endtask

  // Field extremes and each corner of the parameter computation.
  task automatic test_special_samples();
    point_set_t pts;
    pts = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 16'sd12345, -16'sd5000, -16'sd1, 16'sd1};
    load_points(pts);
    send_sample(0, 1);          // start point
    send_sample(1, 1);          // end point
    send_sample(0, 0);          // zero count acts as one, index matches
    send_sample(1, 0);          // zero count, index above it
    send_sample(4096, 4096);    // largest legal count at its end
    send_sample(4095, 4096);
    send_sample(1, 4096);
    send_sample(8191, 8191);    // count clamped, raw fields still equal
    send_sample(4097, 8191);    // count clamped, index above the clamped count
    send_sample(100, 5000);     // count clamped, index inside
    send_sample(8191, 1);       // index far above the count
    send_sample(1, 3);
    send_sample(2, 3);
    send_sample(1, 2);
    send_sample(5461, 8190);
    send_sample(2730, 5461);
    drain_points();
  endtask

  // All control points at one extreme, to push the sum toward saturation.
  task automatic test_extreme_points();
    point_set_t pts;
    foreach (pts[k]) pts[k] = COORD_MAX;
    load_points(pts);
    send_sample(1, 3);
    send_sample(1, 2);
    send_sample(4095, 4096);
    drain_points();
    foreach (pts[k]) pts[k] = COORD_MIN;
    load_points(pts);
    send_sample(2, 3);
    send_sample(1, 2);
    send_sample(1, 4096);
    drain_points();
  endtask

  // Writes past the last control point must change nothing.
  task automatic test_ignored_registers();
    logic [CFG_IDX_BITS-1:0] idxs [$];
    logic [COORD-1:0]        vals [$];
    load_points(random_points());
    for (logic [CFG_IDX_BITS:0] i = CFG_UNUSED_FIRST; i <= CFG_UNUSED_LAST; i++) begin
      idxs.insert(idxs.size(), i[CFG_IDX_BITS-1:0]);
      vals.insert(vals.size(), COORD'($urandom()));
    end
    write_cfg(idxs, vals);
    send_sample(0, 1);
    send_sample(1, 1);
    send_sample(1, 2);
    send_sample(3, 7);
    drain_points();
  endtask

  // Random curves: mostly complete walks and in-range samples, some raw field noise.
  task automatic test_random_curves();
    point_set_t          pts;
    logic [IDX_BITS-1:0] walk_idx;
    logic [IDX_BITS-1:0] walk_cnt;
    bit                  walking;
    int                  mode;
    int                  cnt;
    walking = 1'b0;
    walk_idx = '0;
    walk_cnt = '0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pts = random_points();
      if (ph == 1) foreach (pts[k]) pts[k] = (k % 2) ? COORD_MIN : COORD_MAX;
      load_points(pts);
      sender_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
      sink_stalls = (ph != 0) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        mode = $urandom_range(0, 99);
        if (walking || mode < 50) begin
          if (!walking) begin
            walk_cnt = IDX_BITS'($urandom_range(1, 20));
            walk_idx = '0;
            walking  = 1'b1;
          end
          send_sample(walk_idx, walk_cnt);
          if (walk_idx == walk_cnt) walking = 1'b0;
          else walk_idx++;
        end else if (mode < 85) begin
          cnt = $urandom_range(1, MAX_SEGMENTS);
          send_sample(IDX_BITS'($urandom_range(0, cnt)), IDX_BITS'(cnt));
        end else begin
          send_sample(IDX_BITS'($urandom()), IDX_BITS'($urandom()));
        end
      end
      drain_points();
    end
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
  endtask

  // Main sequence.
  initial begin
    foreach (ctrl_pts[k]) ctrl_pts[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_points();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_special_samples();
    test_extreme_points();
    test_ignored_registers();
    test_random_curves();
    if (pending_points.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Output ready: long runs high, short and occasional long stalls.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = idle_span();
      if (!sink_stalls || ready_pick == 0) begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(0, 8);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    <= ready_pick - 1;
      end
    end
  end

  // Compare each output transaction with the oldest expected point.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_point.x    = m_axis_tdata[COORD-1:0];
      got_point.y    = m_axis_tdata[2*COORD-1:COORD];
      got_point.last = m_axis_tlast;
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point", '0, got_point);
      end else begin
        want_point = pending_points.pop_front();
        if (got_point !== want_point) report_mismatch("point mismatch", want_point, got_point);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== cubic_bezier_point_evaluator.f =====
+incdir+rtl/core
rtl/core/bzr_pkg.sv
rtl/core/bzr_div.sv
rtl/core/bzr_wgt.sv
rtl/core/bzr_mac.sv
rtl/core/cubic_bezier_point_evaluator.sv
test/tb_top.sv
